### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the transfer sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define AST_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/i2cbts_pkg.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Widths, codes and shared types of the buffered I2C transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbts_pkg;

	// Buffer geometry.
	localparam int BufDepth = 16;
	localparam int AddrW    = (BufDepth > 1) ? $clog2(BufDepth) : 1;
	localparam int PosW     = $clog2(BufDepth + 1);

	// Fixed field widths.
	localparam int ReqW   = 2;
	localparam int EvW    = 4;
	localparam int ByteW  = 8;
	localparam int IdxW   = 4;
	localparam int ActW   = 3;
	localparam int KindW  = 3;
	localparam int CountW = 5;
	localparam int ModeW  = 3;
	localparam int CfgIdxW = 2;

	// Request types.
	localparam logic [ReqW-1:0] REQ_EVENT = 2'd0;
	localparam logic [ReqW-1:0] REQ_TX_WR = 2'd1;
	localparam logic [ReqW-1:0] REQ_RX_RD = 2'd2;

	// Bus status events.
	localparam logic [EvW-1:0] EV_START      = 4'd0;
	localparam logic [EvW-1:0] EV_BUS_ERR    = 4'd1;
	localparam logic [EvW-1:0] EV_MT_ACK     = 4'd2;
	localparam logic [EvW-1:0] EV_MT_NACK    = 4'd3;
	localparam logic [EvW-1:0] EV_ARB_LOST   = 4'd4;
	localparam logic [EvW-1:0] EV_MR_DATA_ACK  = 4'd5;
	localparam logic [EvW-1:0] EV_MR_SLA_ACK   = 4'd6;
	localparam logic [EvW-1:0] EV_MR_DATA_NACK = 4'd7;
	localparam logic [EvW-1:0] EV_MR_SLA_NACK  = 4'd8;
	localparam logic [EvW-1:0] EV_SR_ADDR    = 4'd9;
	localparam logic [EvW-1:0] EV_SR_DATA_ACK  = 4'd10;
	localparam logic [EvW-1:0] EV_SR_DATA_NACK = 4'd11;
	localparam logic [EvW-1:0] EV_SR_STOP    = 4'd12;
	localparam logic [EvW-1:0] EV_ST_ADDR    = 4'd13;
	localparam logic [EvW-1:0] EV_ST_DATA_ACK  = 4'd14;
	localparam logic [EvW-1:0] EV_ST_DONE    = 4'd15;

	// Bus actions.
	localparam logic [ActW-1:0] ACT_ACK  = 3'd0;
	localparam logic [ActW-1:0] ACT_NACK = 3'd1;
	localparam logic [ActW-1:0] ACT_STOP = 3'd2;
	localparam logic [ActW-1:0] ACT_HOLD = 3'd3;
	localparam logic [ActW-1:0] ACT_NONE = 3'd4;

	// Controller modes.
	localparam logic [ModeW-1:0] MODE_MA_IDLE = 3'd0;
	localparam logic [ModeW-1:0] MODE_MA_HOLD = 3'd1;
	localparam logic [ModeW-1:0] MODE_SL_IDLE = 3'd2;
	localparam logic [ModeW-1:0] MODE_SL_RX   = 3'd3;
	localparam logic [ModeW-1:0] MODE_SL_TX   = 3'd4;

	// Transfer kinds.
	localparam logic [KindW-1:0] KIND_ERR = 3'd0;
	localparam logic [KindW-1:0] KIND_MT  = 3'd1;
	localparam logic [KindW-1:0] KIND_MR  = 3'd2;
	localparam logic [KindW-1:0] KIND_SR  = 3'd3;
	localparam logic [KindW-1:0] KIND_ST  = 3'd4;

	// Configuration register indices.
	localparam logic [CfgIdxW-1:0] CFG_ROLE_SLAVE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_TARGET     = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RESTART    = 2'd2;

	localparam logic [ByteW-1:0] OVERRUN_BYTE = 8'hFF;

	// Write port of the two byte stores.
	typedef struct packed {
		logic             tx_we;
		logic [AddrW-1:0] tx_addr;
		logic             rx_we;
		logic [AddrW-1:0] rx_addr;
		logic [ByteW-1:0] wdata;
	} buf_wr_t;

	// One result beat.
	typedef struct packed {
		logic [ActW-1:0]   bus_action;
		logic              tx_valid;
		logic [ByteW-1:0]  send_byte;
		logic              xfer_done;
		logic [KindW-1:0]  xfer_kind;
		logic              xfer_is_read;
		logic [CountW-1:0] xfer_count;
		logic [ByteW-1:0]  read_data;
		logic [ModeW-1:0]  ctrl_mode;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/i2cbts_ifs.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbts_req_if;
	logic                          valid;
	logic                          ready;
	logic [i2cbts_pkg::ReqW-1:0]   req_type;
	logic [i2cbts_pkg::EvW-1:0]    bus_event;
	logic [i2cbts_pkg::ByteW-1:0]  data_in;
	logic [i2cbts_pkg::IdxW-1:0]   buf_index;

	modport source (output valid, req_type, bus_event, data_in, buf_index, input ready);
	modport sink   (input valid, req_type, bus_event, data_in, buf_index, output ready);
endinterface

interface i2cbts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [i2cbts_pkg::ActW-1:0]   bus_action;
	logic                          tx_valid;
	logic [i2cbts_pkg::ByteW-1:0]  send_byte;
	logic                          xfer_done;
	logic [i2cbts_pkg::KindW-1:0]  xfer_kind;
	logic                          xfer_is_read;
	logic [i2cbts_pkg::CountW-1:0] xfer_count;
	logic [i2cbts_pkg::ByteW-1:0]  read_data;
	logic [i2cbts_pkg::ModeW-1:0]  ctrl_mode;

	modport source (output valid, bus_action, tx_valid, send_byte, xfer_done, xfer_kind,
		xfer_is_read, xfer_count, read_data, ctrl_mode, input ready);
	modport sink   (input valid, bus_action, tx_valid, send_byte, xfer_done, xfer_kind,
		xfer_is_read, xfer_count, read_data, ctrl_mode, output ready);
endinterface

interface i2cbts_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [i2cbts_pkg::CfgIdxW-1:0] index;
	logic [i2cbts_pkg::ByteW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/i2cbts_buffers.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer byte stores
// Transmit and receive byte stores, each with one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbts_buffers (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire i2cbts_pkg::buf_wr_t              wr,
	input  wire logic [i2cbts_pkg::AddrW-1:0]     tx_raddr,
	input  wire logic [i2cbts_pkg::AddrW-1:0]     rx_raddr,
	output logic      [i2cbts_pkg::ByteW-1:0]     tx_rdata,
	output logic      [i2cbts_pkg::ByteW-1:0]     rx_rdata
);

	logic [i2cbts_pkg::ByteW-1:0] tx_mem_q [i2cbts_pkg::BufDepth];
	logic [i2cbts_pkg::ByteW-1:0] rx_mem_q [i2cbts_pkg::BufDepth];

	// Both stores come out of reset holding zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < i2cbts_pkg::BufDepth; i++) begin
				tx_mem_q[i] <= '0;
				rx_mem_q[i] <= '0;
			end
		end else begin
			if (wr.tx_we) begin
				tx_mem_q[wr.tx_addr] <= wr.wdata;
			end
			if (wr.rx_we) begin
				rx_mem_q[wr.rx_addr] <= wr.wdata;
			end
		end
	end

	// Read ports feed the single-pass logic of the current item.
	assign tx_rdata = tx_mem_q[tx_raddr];
	assign rx_rdata = rx_mem_q[rx_raddr];

endmodule

`default_nettype wire

### rtl/i2c_buffered_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C buffered transfer sequencer
// Turns bus status events into bus actions, bytes to send and transfer reports.
// ----------------------------------------------------------------------------
// The sequencer takes one request beat per clock cycle while the result port
// is not stalled, and returns exactly one result beat for it. An accepted beat
// is held in an input register, is resolved against the transmit and receive
// stores and the buffer positions in a single combinational pass, and lands in
// the result register, so a new request can be taken while the last one is
// still in flight. The sustained rate is set by that one pass through the store
// read ports and position update. A stalled result port stops the input only
// once both registers are full. Configuration writes are taken at once and
// should be made only while no request is in flight.
`default_nettype none

module i2c_buffered_transfer_sequencer (
	input wire logic    clk,
	input wire logic    arst_n,
	i2cbts_req_if.sink  req,
	i2cbts_rsp_if.source rsp,
	i2cbts_cfg_if.sink  cfg
);

	// Configuration registers.
	logic [i2cbts_pkg::ByteW-1:0] target_addr_rw_q;
	logic                         restart_after_tx_q;

	// Sequencer state.
	logic [i2cbts_pkg::PosW-1:0]  tx_pos_q;
	logic [i2cbts_pkg::PosW-1:0]  rx_pos_q;
	logic [i2cbts_pkg::ModeW-1:0] mode_q;

	// Input register.
	logic                         valid_s1;
	logic [i2cbts_pkg::ReqW-1:0]  req_type_s1;
	logic [i2cbts_pkg::EvW-1:0]   bus_event_s1;
	logic [i2cbts_pkg::ByteW-1:0] data_in_s1;
	logic [i2cbts_pkg::IdxW-1:0]  buf_index_s1;

	// Result register.
	logic                         rsp_valid_q;
	i2cbts_pkg::rsp_t             rsp_q;

	// Pass logic.
	logic                         advance;
	logic                         take;
	logic                         step;
	i2cbts_pkg::rsp_t             res;
	i2cbts_pkg::buf_wr_t          buf_wr;
	logic [i2cbts_pkg::AddrW-1:0] tx_raddr;
	logic [i2cbts_pkg::ByteW-1:0] tx_rdata;
	logic [i2cbts_pkg::ByteW-1:0] rx_rdata;
	logic [i2cbts_pkg::PosW-1:0]  tx_pos_nxt;
	logic [i2cbts_pkg::PosW-1:0]  rx_pos_nxt;
	logic [i2cbts_pkg::ModeW-1:0] mode_nxt;
	logic                         rx_store;
	logic                         tx_room;
	logic                         rx_room;
	logic                         idx_ok;

	// Handshake: the input register moves on whenever the result slot frees.
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;
	assign step      = valid_s1 && advance;
	assign cfg.ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_type_s1  <= req.req_type;
			bus_event_s1 <= req.bus_event;
			data_in_s1   <= req.data_in;
			buf_index_s1 <= req.buf_index;
		end
	end

	// Byte stores.
	assign tx_raddr = (bus_event_s1 == i2cbts_pkg::EV_ST_ADDR) ? '0
		: tx_pos_q[i2cbts_pkg::AddrW-1:0];

	i2cbts_buffers u_buffers (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (buf_wr),
		.tx_raddr (tx_raddr),
		.rx_raddr (i2cbts_pkg::AddrW'(buf_index_s1)),
		.tx_rdata (tx_rdata),
		.rx_rdata (rx_rdata)
	);

	assign tx_room = 32'(tx_pos_q) < 32'(i2cbts_pkg::BufDepth);
	assign rx_room = 32'(rx_pos_q) < 32'(i2cbts_pkg::BufDepth);
	assign idx_ok  = 32'(buf_index_s1) < 32'(i2cbts_pkg::BufDepth);

	// Single pass: resolve the held request against the current state.
	always_comb begin
		res            = '0;
		res.bus_action = i2cbts_pkg::ACT_NONE;
		tx_pos_nxt     = tx_pos_q;
		mode_nxt       = mode_q;
		rx_store       = 1'b0;

		buf_wr         = '0;
		buf_wr.wdata   = data_in_s1;
		buf_wr.tx_addr = i2cbts_pkg::AddrW'(buf_index_s1);
		buf_wr.rx_addr = rx_pos_q[i2cbts_pkg::AddrW-1:0];

		case (req_type_s1)
			i2cbts_pkg::REQ_TX_WR: begin
				buf_wr.tx_we = step && idx_ok;
			end
			i2cbts_pkg::REQ_RX_RD: begin
				res.read_data = idx_ok ? rx_rdata : i2cbts_pkg::OVERRUN_BYTE;
			end
			i2cbts_pkg::REQ_EVENT: begin
				// Receive stores happen on these events while room remains.
				rx_store = (bus_event_s1 == i2cbts_pkg::EV_MR_DATA_ACK)
					|| (bus_event_s1 == i2cbts_pkg::EV_MR_DATA_NACK)
					|| (bus_event_s1 == i2cbts_pkg::EV_SR_DATA_ACK)
					|| (bus_event_s1 == i2cbts_pkg::EV_SR_DATA_NACK);
			end
			default: begin
			end
		endcase

		buf_wr.rx_we = step && rx_store && rx_room;
		rx_pos_nxt   = (rx_store && rx_room) ? rx_pos_q + 1'b1 : rx_pos_q;

		if (req_type_s1 == i2cbts_pkg::REQ_EVENT) begin
			case (bus_event_s1)
				i2cbts_pkg::EV_START: begin
					tx_pos_nxt     = '0;
					rx_pos_nxt     = '0;
					res.tx_valid   = 1'b1;
					res.send_byte  = target_addr_rw_q;
					res.bus_action = i2cbts_pkg::ACT_ACK;
				end
				i2cbts_pkg::EV_BUS_ERR: begin
					res.bus_action = i2cbts_pkg::ACT_STOP;
					mode_nxt       = i2cbts_pkg::MODE_MA_IDLE;
					res.xfer_done  = 1'b1;
					res.xfer_kind  = i2cbts_pkg::KIND_ERR;
				end
				i2cbts_pkg::EV_MT_ACK: begin
					if (tx_room) begin
						res.tx_valid   = 1'b1;
						res.send_byte  = tx_rdata;
						tx_pos_nxt     = tx_pos_q + 1'b1;
						res.bus_action = i2cbts_pkg::ACT_ACK;
					end else begin
						// Out of data: hold for a repeated start or finish.
						if (restart_after_tx_q) begin
							res.bus_action = i2cbts_pkg::ACT_HOLD;
							mode_nxt       = i2cbts_pkg::MODE_MA_HOLD;
						end else begin
							res.bus_action = i2cbts_pkg::ACT_STOP;
							mode_nxt       = i2cbts_pkg::MODE_MA_IDLE;
						end
						res.xfer_done  = 1'b1;
						res.xfer_kind  = i2cbts_pkg::KIND_MT;
						res.xfer_count = i2cbts_pkg::CountW'(tx_pos_q);
					end
				end
				i2cbts_pkg::EV_MT_NACK: begin
					res.bus_action = i2cbts_pkg::ACT_STOP;
					mode_nxt       = i2cbts_pkg::MODE_MA_IDLE;
					res.xfer_done  = 1'b1;
					res.xfer_kind  = i2cbts_pkg::KIND_MT;
					res.xfer_count = i2cbts_pkg::CountW'(tx_pos_q);
				end
				i2cbts_pkg::EV_ARB_LOST: begin
					res.bus_action = i2cbts_pkg::ACT_NACK;
					mode_nxt       = i2cbts_pkg::MODE_MA_IDLE;
					res.xfer_done  = 1'b1;
					res.xfer_kind  = i2cbts_pkg::KIND_ERR;
				end
				i2cbts_pkg::EV_MR_DATA_ACK, i2cbts_pkg::EV_MR_SLA_ACK: begin
					// Nack ahead of the byte that fills the last entry.
					res.bus_action = (32'(rx_pos_nxt) + 32'd1 < 32'(i2cbts_pkg::BufDepth))
						? i2cbts_pkg::ACT_ACK : i2cbts_pkg::ACT_NACK;
				end
				i2cbts_pkg::EV_MR_DATA_NACK, i2cbts_pkg::EV_MR_SLA_NACK: begin
					res.bus_action   = i2cbts_pkg::ACT_STOP;
					mode_nxt         = i2cbts_pkg::MODE_MA_IDLE;
					res.xfer_done    = 1'b1;
					res.xfer_kind    = i2cbts_pkg::KIND_MR;
					res.xfer_is_read = 1'b1;
					res.xfer_count   = i2cbts_pkg::CountW'(rx_pos_nxt);
				end
				i2cbts_pkg::EV_SR_ADDR: begin
					mode_nxt       = i2cbts_pkg::MODE_SL_RX;
					rx_pos_nxt     = '0;
					res.bus_action = i2cbts_pkg::ACT_ACK;
				end
				i2cbts_pkg::EV_SR_DATA_ACK: begin
					res.bus_action = rx_room ? i2cbts_pkg::ACT_ACK : i2cbts_pkg::ACT_NACK;
				end
				i2cbts_pkg::EV_SR_DATA_NACK: begin
					res.bus_action = i2cbts_pkg::ACT_NACK;
				end
				i2cbts_pkg::EV_SR_STOP: begin
					mode_nxt         = i2cbts_pkg::MODE_SL_IDLE;
					res.xfer_done    = 1'b1;
					res.xfer_kind    = i2cbts_pkg::KIND_SR;
					res.xfer_is_read = 1'b1;
					res.xfer_count   = i2cbts_pkg::CountW'(rx_pos_q);
					res.bus_action   = i2cbts_pkg::ACT_ACK;
				end
				i2cbts_pkg::EV_ST_ADDR: begin
					mode_nxt       = i2cbts_pkg::MODE_SL_TX;
					res.tx_valid   = 1'b1;
					res.send_byte  = tx_rdata;
					tx_pos_nxt     = i2cbts_pkg::PosW'(1);
					res.bus_action = i2cbts_pkg::ACT_ACK;
				end
				i2cbts_pkg::EV_ST_DATA_ACK: begin
					res.tx_valid = 1'b1;
					if (tx_room) begin
						res.send_byte  = tx_rdata;
						tx_pos_nxt     = tx_pos_q + 1'b1;
						res.bus_action = i2cbts_pkg::ACT_ACK;
					end else begin
						// Master reads past the data: pad with the overrun byte.
						res.send_byte  = i2cbts_pkg::OVERRUN_BYTE;
						res.bus_action = i2cbts_pkg::ACT_NACK;
					end
				end
				default: begin
					mode_nxt       = i2cbts_pkg::MODE_SL_IDLE;
					res.xfer_done  = 1'b1;
					res.xfer_kind  = i2cbts_pkg::KIND_ST;
					res.xfer_count = i2cbts_pkg::CountW'(tx_pos_q);
					res.bus_action = i2cbts_pkg::ACT_ACK;
				end
			endcase
		end

		res.ctrl_mode = mode_nxt;
	end

	// State update and configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_pos_q           <= '0;
			rx_pos_q           <= '0;
			mode_q             <= i2cbts_pkg::MODE_MA_IDLE;
			target_addr_rw_q   <= '0;
			restart_after_tx_q <= 1'b0;
		end else begin
			if (step) begin
				tx_pos_q <= tx_pos_nxt;
				rx_pos_q <= rx_pos_nxt;
				mode_q   <= mode_nxt;
			end
			if (cfg.valid) begin
				case (cfg.index)
					i2cbts_pkg::CFG_ROLE_SLAVE: begin
						// The role only matters through the idle mode, so an idle controller
						// follows the new role at once unless a request is resolved in the same cycle.
						if (!step && (mode_q == i2cbts_pkg::MODE_MA_IDLE
							|| mode_q == i2cbts_pkg::MODE_SL_IDLE)) begin
							mode_q <= cfg.data[0] ? i2cbts_pkg::MODE_SL_IDLE
								: i2cbts_pkg::MODE_MA_IDLE;
						end
					end
					i2cbts_pkg::CFG_TARGET: begin
						target_addr_rw_q <= cfg.data;
					end
					i2cbts_pkg::CFG_RESTART: begin
						restart_after_tx_q <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.bus_action   = rsp_q.bus_action;
	assign rsp.tx_valid     = rsp_q.tx_valid;
	assign rsp.send_byte    = rsp_q.send_byte;
	assign rsp.xfer_done    = rsp_q.xfer_done;
	assign rsp.xfer_kind    = rsp_q.xfer_kind;
	assign rsp.xfer_is_read = rsp_q.xfer_is_read;
	assign rsp.xfer_count   = rsp_q.xfer_count;
	assign rsp.read_data    = rsp_q.read_data;
	assign rsp.ctrl_mode    = rsp_q.ctrl_mode;

endmodule

`default_nettype wire

### rtl/i2cbts_checker.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2cbts_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [i2cbts_pkg::ActW-1:0]       rsp_bus_action,
	input wire logic                              rsp_tx_valid,
	input wire logic [i2cbts_pkg::ByteW-1:0]      rsp_send_byte,
	input wire logic                              rsp_xfer_done,
	input wire logic [i2cbts_pkg::KindW-1:0]      rsp_xfer_kind,
	input wire logic                              rsp_xfer_is_read,
	input wire logic [i2cbts_pkg::CountW-1:0]     rsp_xfer_count
);

	// A stalled result beat keeps its action and count.
	`AST_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bus_action) && $stable(rsp_xfer_count), "stalled result beat changed")

	// Without a report the report fields stay clear.
	`AST_IMP(a_no_report, clk, arst_n, rsp_valid && !rsp_xfer_done, rsp_xfer_kind == i2cbts_pkg::KIND_ERR && !rsp_xfer_is_read && rsp_xfer_count == '0, "report fields set without a report")

	// No byte is offered unless one is to be sent.
	`AST_IMP(a_no_send, clk, arst_n, rsp_valid && !rsp_tx_valid, rsp_send_byte == '0, "send byte set without tx_valid")

	// An error report carries no count and releases or stops the bus.
	`AST_IMP(a_err_report, clk, arst_n, rsp_valid && rsp_xfer_done && rsp_xfer_kind == i2cbts_pkg::KIND_ERR, rsp_xfer_count == '0 && (rsp_bus_action == i2cbts_pkg::ACT_STOP || rsp_bus_action == i2cbts_pkg::ACT_NACK), "bad error report")

	// A master receive report is a read that ends with a stop.
	`AST_IMP(a_mr_report, clk, arst_n, rsp_valid && rsp_xfer_done && rsp_xfer_kind == i2cbts_pkg::KIND_MR, rsp_xfer_is_read && rsp_bus_action == i2cbts_pkg::ACT_STOP, "bad master receive report")

endmodule

bind i2c_buffered_transfer_sequencer i2cbts_checker u_i2cbts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_bus_action   (rsp.bus_action),
	.rsp_tx_valid     (rsp.tx_valid),
	.rsp_send_byte    (rsp.send_byte),
	.rsp_xfer_done    (rsp.xfer_done),
	.rsp_xfer_kind    (rsp.xfer_kind),
	.rsp_xfer_is_read (rsp.xfer_is_read),
	.rsp_xfer_count   (rsp.xfer_count)
);

`default_nettype wire
